// ----- rtl/valloc_pkg.sv -----
// ----------------------------------------------------------------------------
// valloc_pkg
// Shared constants, request codes and controller/datapath link types for the
// synth voice allocator.
// ----------------------------------------------------------------------------
package valloc_pkg;

  localparam int Voices = 16;
  localparam int VidW   = $clog2(Voices);
  localparam int CntW   = $clog2(Voices + 1);
  localparam int ReqW   = 3;
  localparam int ChW    = 4;
  localparam int NoteW  = 7;
  localparam int SelW   = 4;
  localparam int IdW    = 4;

  localparam logic [ReqW-1:0] REQ_ALLOC       = 3'd0;
  localparam logic [ReqW-1:0] REQ_RELEASE     = 3'd1;
  localparam logic [ReqW-1:0] REQ_CLEAR       = 3'd2;
  localparam logic [ReqW-1:0] REQ_SEARCH_NEW  = 3'd3;
  localparam logic [ReqW-1:0] REQ_SEARCH_NEXT = 3'd4;

  typedef enum logic [3:0] {
    DP_NONE,
    DP_LATCH,
    DP_ALLOC,
    DP_CLEAR,
    DP_RELEASE,
    DP_SCAN_START,
    DP_SCAN_NEXT,
    DP_WALK_NEWEST,
    DP_WALK_FROM,
    DP_WALK_NEXT,
    DP_WALK_STOP,
    DP_EXHAUST
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic [ReqW-1:0] req;
    logic            rel_ok;
    logic            mode_active;
    logic            loc_done;
    logic            loc_at_front;
    logic            pos_at_front;
    logic            walk_used;
    logic            walk_match;
  } dp_stat_t;

endpackage

// ----- rtl/valloc_dp.sv -----
// ----------------------------------------------------------------------------
// valloc_dp
// Datapath: voice order list, per-voice records, search cursor and the
// shared position counter used for locating and walking the list.
// ----------------------------------------------------------------------------
module valloc_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  valloc_pkg::dp_cmd_t           cmd_i,
  output valloc_pkg::dp_stat_t          stat_o,
  input  logic [valloc_pkg::ReqW-1:0]   req_type_i,
  input  logic [valloc_pkg::ChW-1:0]    channel_i,
  input  logic [valloc_pkg::NoteW-1:0]  note_i,
  input  logic [valloc_pkg::SelW-1:0]   voice_sel_i,
  input  logic                          match_note_i,
  output logic [valloc_pkg::IdW-1:0]    voice_id_o,
  output logic                          found_o
);

  localparam int Voices = valloc_pkg::Voices;
  localparam int VidW   = valloc_pkg::VidW;
  localparam int CntW   = valloc_pkg::CntW;
  localparam logic [VidW-1:0] LastPos = VidW'(Voices - 1);

  logic [VidW-1:0]             order_q [Voices];
  logic [VidW-1:0]             order_d [Voices];
  logic [valloc_pkg::ChW-1:0]  chan_q  [Voices];
  logic [valloc_pkg::ChW-1:0]  chan_d  [Voices];
  logic [valloc_pkg::NoteW-1:0] note_q [Voices];
  logic [valloc_pkg::NoteW-1:0] note_d [Voices];
  logic [Voices-1:0]           used_q, used_d;
  logic [CntW-1:0]             free_cnt_q, free_cnt_d;
  logic [VidW-1:0]             cursor_q, cursor_d;
  logic                        mode_q, mode_d;
  logic [VidW-1:0]             pos_q, pos_d;
  logic [VidW-1:0]             res_vid_q, res_vid_d;
  logic                        res_found_q, res_found_d;

  // request beat, no reset needed
  logic [valloc_pkg::ReqW-1:0]  req_q;
  logic [valloc_pkg::ChW-1:0]   ch_q;
  logic [valloc_pkg::NoteW-1:0] nt_q;
  logic [valloc_pkg::SelW-1:0]  sel_q;
  logic                         mn_q;

  logic            sel_ok;
  logic [VidW-1:0] sel_idx;
  logic [VidW-1:0] tgt;
  logic            loc_hit;
  logic [VidW-1:0] loc_pos;
  logic [VidW-1:0] wv;
  logic [CntW-1:0] p_ext;
  logic [CntW-1:0] f_lim;
  logic [VidW-1:0] front_v;

  assign sel_ok  = ({{CntW{1'b0}}, sel_q} < (CntW + valloc_pkg::SelW)'(Voices));
  assign sel_idx = VidW'(sel_q);
  assign tgt     = (req_q == valloc_pkg::REQ_RELEASE) ? sel_idx : cursor_q;
  assign loc_hit = (order_q[pos_q] == tgt);
  assign loc_pos = loc_hit ? pos_q : '0;
  assign wv      = order_q[pos_q];
  assign front_v = order_q[0];
  assign p_ext   = CntW'(loc_pos);
  assign f_lim   = (free_cnt_q < p_ext) ? free_cnt_q : p_ext;

  always_comb begin
    stat_o.req          = req_q;
    stat_o.rel_ok       = sel_ok && used_q[sel_idx];
    stat_o.mode_active  = mode_q;
    stat_o.loc_done     = loc_hit || (pos_q == LastPos);
    stat_o.loc_at_front = (loc_pos == '0);
    stat_o.pos_at_front = (pos_q == '0);
    stat_o.walk_used    = used_q[wv];
    stat_o.walk_match   = (chan_q[wv] == ch_q) && (!mn_q || (note_q[wv] == nt_q));
  end

  always_comb begin
    order_d     = order_q;
    chan_d      = chan_q;
    note_d      = note_q;
    used_d      = used_q;
    free_cnt_d  = free_cnt_q;
    cursor_d    = cursor_q;
    mode_d      = mode_q;
    pos_d       = pos_q;
    res_vid_d   = res_vid_q;
    res_found_d = res_found_q;
    unique case (cmd_i.op)
      valloc_pkg::DP_NONE: ;
      valloc_pkg::DP_LATCH: begin
        res_vid_d   = '0;
        res_found_d = 1'b0;
      end
      valloc_pkg::DP_ALLOC: begin
        // rotate the front voice to the newest end
        for (int i = 0; i < Voices - 1; i++) begin
          order_d[i] = order_q[i + 1];
        end
        order_d[Voices - 1] = front_v;
        if (free_cnt_q != '0) begin
          free_cnt_d = free_cnt_q - CntW'(1);
        end
        chan_d[front_v] = ch_q;
        note_d[front_v] = nt_q;
        used_d[front_v] = 1'b1;
        res_vid_d       = front_v;
        res_found_d     = 1'b1;
      end
      valloc_pkg::DP_CLEAR: begin
        used_d     = '0;
        free_cnt_d = CntW'(Voices);
      end
      valloc_pkg::DP_RELEASE: begin
        // open a slot just after the free voices and drop the voice there
        for (int i = 1; i < Voices; i++) begin
          if ((CntW'(i) > f_lim) && (CntW'(i) <= p_ext)) begin
            order_d[i] = order_q[i - 1];
          end
        end
        for (int i = 0; i < Voices; i++) begin
          if (CntW'(i) == f_lim) begin
            order_d[i] = sel_idx;
          end
        end
        used_d[sel_idx] = 1'b0;
        if (free_cnt_q < CntW'(Voices)) begin
          free_cnt_d = free_cnt_q + CntW'(1);
        end
      end
      valloc_pkg::DP_SCAN_START:  pos_d = '0;
      valloc_pkg::DP_SCAN_NEXT:   pos_d = pos_q + VidW'(1);
      valloc_pkg::DP_WALK_NEWEST: pos_d = LastPos;
      valloc_pkg::DP_WALK_FROM:   pos_d = loc_pos - VidW'(1);
      valloc_pkg::DP_WALK_NEXT:   pos_d = pos_q - VidW'(1);
      valloc_pkg::DP_WALK_STOP: begin
        // stops on a free voice (miss) or on a matching used voice (hit)
        cursor_d    = wv;
        mode_d      = 1'b1;
        res_found_d = used_q[wv];
        res_vid_d   = used_q[wv] ? wv : '0;
      end
      valloc_pkg::DP_EXHAUST: mode_d = 1'b0;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Voices; i++) begin
        order_q[i] <= VidW'(i);
        chan_q[i]  <= '0;
        note_q[i]  <= '0;
      end
      used_q      <= '0;
      free_cnt_q  <= CntW'(Voices);
      cursor_q    <= '0;
      mode_q      <= 1'b0;
      pos_q       <= '0;
      res_vid_q   <= '0;
      res_found_q <= 1'b0;
    end else begin
      order_q     <= order_d;
      chan_q      <= chan_d;
      note_q      <= note_d;
      used_q      <= used_d;
      free_cnt_q  <= free_cnt_d;
      cursor_q    <= cursor_d;
      mode_q      <= mode_d;
      pos_q       <= pos_d;
      res_vid_q   <= res_vid_d;
      res_found_q <= res_found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == valloc_pkg::DP_LATCH) begin
      req_q <= req_type_i;
      ch_q  <= channel_i;
      nt_q  <= note_i;
      sel_q <= voice_sel_i;
      mn_q  <= match_note_i;
    end
  end

  assign voice_id_o = valloc_pkg::IdW'(res_vid_q);
  assign found_o    = res_found_q;

endmodule

// ----- rtl/valloc_ctrl.sv -----
// ----------------------------------------------------------------------------
// valloc_ctrl
// Controller: sequences each request through decode, where needed a list
// scan and search walk, and the one-cycle result strobe.
// ----------------------------------------------------------------------------
module valloc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  output logic                 done_o,
  output valloc_pkg::dp_cmd_t  cmd_o,
  input  valloc_pkg::dp_stat_t stat_i
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_DECODE = 6'b000010,
    ST_LOCATE = 6'b000100,
    ST_WALK   = 6'b001000,
    ST_SPARE  = 6'b010000,
    ST_REPLY  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = valloc_pkg::DP_NONE;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.op = valloc_pkg::DP_LATCH;
          state_d  = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_d = ST_REPLY;
        case (stat_i.req)
          valloc_pkg::REQ_ALLOC: cmd_o.op = valloc_pkg::DP_ALLOC;
          valloc_pkg::REQ_CLEAR: cmd_o.op = valloc_pkg::DP_CLEAR;
          valloc_pkg::REQ_RELEASE: begin
            if (stat_i.rel_ok) begin
              cmd_o.op = valloc_pkg::DP_SCAN_START;
              state_d  = ST_LOCATE;
            end
          end
          valloc_pkg::REQ_SEARCH_NEW: begin
            cmd_o.op = valloc_pkg::DP_WALK_NEWEST;
            state_d  = ST_WALK;
          end
          valloc_pkg::REQ_SEARCH_NEXT: begin
            if (stat_i.mode_active) begin
              cmd_o.op = valloc_pkg::DP_SCAN_START;
              state_d  = ST_LOCATE;
            end
          end
          default: ;
        endcase
      end
      ST_LOCATE: begin
        // find the list position of the released voice or the cursor voice
        if (!stat_i.loc_done) begin
          cmd_o.op = valloc_pkg::DP_SCAN_NEXT;
        end else if (stat_i.req == valloc_pkg::REQ_RELEASE) begin
          cmd_o.op = valloc_pkg::DP_RELEASE;
          state_d  = ST_REPLY;
        end else if (stat_i.loc_at_front) begin
          cmd_o.op = valloc_pkg::DP_EXHAUST;
          state_d  = ST_REPLY;
        end else begin
          cmd_o.op = valloc_pkg::DP_WALK_FROM;
          state_d  = ST_WALK;
        end
      end
      ST_WALK: begin
        if (!stat_i.walk_used || stat_i.walk_match) begin
          cmd_o.op = valloc_pkg::DP_WALK_STOP;
          state_d  = ST_REPLY;
        end else if (stat_i.pos_at_front) begin
          cmd_o.op = valloc_pkg::DP_EXHAUST;
          state_d  = ST_REPLY;
        end else begin
          cmd_o.op = valloc_pkg::DP_WALK_NEXT;
        end
      end
      ST_REPLY: state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = (state_q == ST_REPLY);

endmodule

// ----- rtl/synth_voice_allocator.sv -----
// ----------------------------------------------------------------------------
// synth_voice_allocator
// LRU voice allocator with stealing for a polyphonic synth voice pool.
// ----------------------------------------------------------------------------
// Usage:
//   A request beat is taken at a rising edge with start_i high and busy_o low;
//   req_type_i selects allocate, release, clear, search from newest or search
//   next. busy_o stays high until the result beat has been shown.
//   Every request gives exactly one result beat: done_o is high for one cycle
//   with voice_id_o and found_o valid; the receiver cannot stall it.
//   Allocate, clear, ignored and rejected requests go from decode straight to
//   the result beat; release adds a scan of the order list; search from
//   newest walks up to Voices voices; search next scans for the cursor voice
//   and then walks. Both scan and walk step one list position per cycle on
//   the shared position counter of the datapath. A new request is taken the
//   cycle after done.
//   Reset puts the order list in identity order with every voice free, the
//   voice records cleared and the search exhausted; no clearing pass is run.
// ----------------------------------------------------------------------------
module synth_voice_allocator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [valloc_pkg::ReqW-1:0]   req_type_i,
  input  logic [valloc_pkg::ChW-1:0]    channel_i,
  input  logic [valloc_pkg::NoteW-1:0]  note_i,
  input  logic [valloc_pkg::SelW-1:0]   voice_sel_i,
  input  logic                          match_note_i,
  output logic                          done_o,
  output logic [valloc_pkg::IdW-1:0]    voice_id_o,
  output logic                          found_o
);

  valloc_pkg::dp_cmd_t  cmd;
  valloc_pkg::dp_stat_t stat;

  valloc_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .done_o  (done_o),
    .cmd_o   (cmd),
    .stat_i  (stat)
  );

  valloc_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .req_type_i   (req_type_i),
    .channel_i    (channel_i),
    .note_i       (note_i),
    .voice_sel_i  (voice_sel_i),
    .match_note_i (match_note_i),
    .voice_id_o   (voice_id_o),
    .found_o      (found_o)
  );

endmodule

// ----- rtl/valloc_checker.sv -----
// ----------------------------------------------------------------------------
// valloc_checker
// Port-level checks on the request/result sequencing of the allocator.
// ----------------------------------------------------------------------------
module valloc_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         start_i,
  input logic                         busy_o,
  input logic                         done_o,
  input logic [valloc_pkg::IdW-1:0]   voice_id_o,
  input logic                         found_o
);

  // a taken request keeps the block busy until its result
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("busy_o low right after a request beat");

  // result beat only while a request is outstanding
  a_done_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o)
    else $error("done_o without an outstanding request");

  // exactly one result beat, then ready again
  a_done_then_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> (!done_o && !busy_o))
    else $error("result beat not followed by idle");

  // a miss carries voice 0
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !found_o) |-> (voice_id_o == '0))
    else $error("voice_id_o not zero on a miss");

endmodule

bind synth_voice_allocator valloc_checker u_valloc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start_i    (start_i),
  .busy_o     (busy_o),
  .done_o     (done_o),
  .voice_id_o (voice_id_o),
  .found_o    (found_o)
);
